/* rtl/core/lndg_pkg.sv */
// Noise drum generator package: item type, per-kind constants and the LFSR step.
// No dependencies; imported by lndg_voice and lfsr_noise_drum_generator_top.
package lndg_pkg;

    typedef struct packed {
        logic        command;
        logic [1:0]  drum_type;
        logic [14:0] amplitude;
        logic [15:0] length_samples;
    } item_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [1:0] KIND_KICK  = 2'd0;
    localparam logic [1:0] KIND_SNARE = 2'd1;
    localparam logic [1:0] KIND_HIHAT = 2'd2;
    localparam logic [1:0] KIND_HIHAT_ALT = 2'd3;

    localparam logic [14:0] LFSR_SEED = 15'h7FFF;
    localparam logic [16:0] ENV_ONE   = 17'd65536;
    localparam logic [16:0] ENV_FLOOR = 17'd66;
    localparam logic [14:0] MAG_MAX   = 15'h7FFF;

    function automatic logic [8:0] toggle_threshold(input logic [1:0] kind);
        logic [8:0] t;
        unique case (kind)
            KIND_KICK:      t = 9'd259;
            KIND_SNARE:     t = 9'd11;
            KIND_HIHAT:     t = 9'd1;
            KIND_HIHAT_ALT: t = 9'd1;
            default:        t = 9'd1;
        endcase
        return t;
    endfunction

    // Q0.16 decay per sample
    function automatic logic [15:0] decay_factor(input logic [1:0] kind);
        logic [15:0] d;
        unique case (kind)
            KIND_KICK:      d = 16'd65208;
            KIND_SNARE:     d = 16'd65012;
            KIND_HIHAT:     d = 16'd64881;
            KIND_HIHAT_ALT: d = 16'd64881;
            default:        d = 16'd64881;
        endcase
        return d;
    endfunction

    // shift right, feedback into bit 14; every kind but kick also forces it into bit 6
    function automatic logic [14:0] lfsr_step(input logic [14:0] s, input logic [1:0] kind);
        logic       fb;
        logic [14:0] n;
        fb = s[0] ^ s[1];
        n  = {fb, s[14:1]};
        if (kind != KIND_KICK)
        begin
            n[6] = fb;
        end
        return n;
    endfunction

endpackage

/* rtl/core/lfsr_noise_drum_generator_top.sv */
// Noise drum generator top: input word register, voice datapath, result register.
// Depends on lndg_pkg and lndg_voice.
// Path: a tick word passes two registers, the input word register, then the result register.
// Throughput: one word per cycle while the result register can take a tick's sample.
// Start words and idle ticks give no result. Reset (rst_n low, async) idles the voice,
// empties both registers and seeds the LFSR to 0x7FFF with the envelope at 1.0.
module lfsr_noise_drum_generator_top #(
    parameter int unsigned LENGTH_MAX = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               command,
    input  logic [1:0]         drum_type,
    input  logic [14:0]        amplitude,
    input  logic [15:0]        length_samples,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] sample,
    output logic               last
);
    import lndg_pkg::*;

    logic               item_valid_reg;
    item_t              item_reg;
    logic               result_valid_reg;
    logic signed [15:0] sample_reg;
    logic               last_reg;

    logic               voice_active;
    logic signed [15:0] voice_sample;
    logic               voice_last;
    logic               out_free;
    logic               gives_result;
    logic               fire;

    assign out_free     = !result_valid_reg || !result_stall;
    assign gives_result = (item_reg.command == CMD_TICK) && voice_active;
    assign fire         = item_valid_reg && (out_free || !gives_result);
    assign item_stall   = item_valid_reg && !fire;

    lndg_voice #(
        .LENGTH_MAX(LENGTH_MAX)
    ) u_voice (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .active (voice_active),
        .sample (voice_sample),
        .last   (voice_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= '{command: command, drum_type: drum_type,
                          amplitude: amplitude, length_samples: length_samples};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire && gives_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && gives_result)
        begin
            sample_reg <= voice_sample;
            last_reg   <= voice_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;

endmodule

/* rtl/core/lndg_voice.sv */
// Noise drum voice state and per-sample datapath: LFSR, toggle counter, envelope.
// Depends on lndg_pkg.
module lndg_voice #(
    parameter int unsigned LENGTH_MAX = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  lndg_pkg::item_t    item,
    output logic               active,
    output logic signed [15:0] sample,
    output logic               last
);
    import lndg_pkg::*;

    logic [14:0] shift_reg, shift_next;
    logic [16:0] env_reg, env_next;
    logic [8:0]  toggle_reg, toggle_next;
    logic [15:0] left_reg, left_next;
    logic        active_reg, active_next;
    logic [1:0]  kind_reg, kind_next;
    logic [14:0] level_reg, level_next;

    logic [14:0] tick_shift;
    logic [8:0]  tick_toggle;
    logic [31:0] level_prod;
    logic [15:0] mag_full;
    logic [14:0] mag;
    logic [32:0] env_prod;
    logic [16:0] tick_env;
    logic [15:0] tick_left;
    logic [15:0] start_len;

    always_comb
    begin
        if (toggle_reg >= toggle_threshold(kind_reg))
        begin
            tick_toggle = 9'd0;
            tick_shift  = lfsr_step(shift_reg, kind_reg);
        end
        else
        begin
            tick_toggle = toggle_reg + 9'd1;
            tick_shift  = shift_reg;
        end

        level_prod = 32'(level_reg) * 32'(env_reg);
        mag_full   = level_prod[31:16];
        mag        = (mag_full > 16'(MAG_MAX)) ? MAG_MAX : mag_full[14:0];
        sample     = tick_shift[0] ? $signed({1'b0, mag}) : $signed(16'd0 - {1'b0, mag});

        env_prod  = 33'(env_reg) * 33'(decay_factor(kind_reg));
        tick_env  = env_prod[32:16];
        tick_left = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
        last      = (tick_left == 16'd0) || (tick_env < ENV_FLOOR);

        if (32'(item.length_samples) > LENGTH_MAX)
        begin
            start_len = LENGTH_MAX[15:0];
        end
        else
        begin
            start_len = item.length_samples;
        end
    end

    always_comb
    begin
        shift_next  = shift_reg;
        env_next    = env_reg;
        toggle_next = toggle_reg;
        left_next   = left_reg;
        active_next = active_reg;
        kind_next   = kind_reg;
        level_next  = level_reg;
        if (fire)
        begin
            if (item.command == CMD_START)
            begin
                kind_next   = item.drum_type;
                level_next  = item.amplitude;
                left_next   = start_len;
                shift_next  = LFSR_SEED;
                env_next    = ENV_ONE;
                toggle_next = 9'd0;
                active_next = (start_len != 16'd0);
            end
            else if (active_reg)
            begin
                shift_next  = tick_shift;
                toggle_next = tick_toggle;
                env_next    = tick_env;
                left_next   = tick_left;
                active_next = !last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= LFSR_SEED;
            env_reg    <= ENV_ONE;
            toggle_reg <= 9'd0;
            left_reg   <= 16'd0;
            active_reg <= 1'b0;
            kind_reg   <= KIND_KICK;
            level_reg  <= 15'd0;
        end
        else
        begin
            shift_reg  <= shift_next;
            env_reg    <= env_next;
            toggle_reg <= toggle_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            kind_reg   <= kind_next;
            level_reg  <= level_next;
        end
    end

    assign active = active_reg;

endmodule
